// ----- design/tcw_pkg.sv -----
package tcw_pkg;

	// Field widths of the requests on both channels
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = 11;
	localparam int COUNT_W = 7;

	// Character codes the console reacts to
	localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
	localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_SGR_END  = 8'h6D;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;

	// Attribute after reset: light grey on black
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [ATTR_W-1:0] ATTR_NONE  = 8'h00;

	// Saturation value of the code accumulator; matches no colour range
	localparam logic [7:0] CODE_SAT = 8'hFF;

	// SGR colour code ranges
	localparam logic [7:0] FG_LO        = 8'd30;
	localparam logic [7:0] FG_HI        = 8'd37;
	localparam logic [7:0] BG_LO        = 8'd40;
	localparam logic [7:0] BG_HI        = 8'd47;
	localparam logic [7:0] FG_BRIGHT_LO = 8'd90;
	localparam logic [7:0] FG_BRIGHT_HI = 8'd97;
	localparam logic [7:0] BG_BRIGHT_LO = 8'd100;
	localparam logic [7:0] BG_BRIGHT_HI = 8'd107;

	// ANSI colour number to VGA palette index
	localparam logic [3:0] ANSI_TO_VGA [16] = '{
		4'h0, 4'h4, 4'h2, 4'h6, 4'h1, 4'h5, 4'h3, 4'h7,
		4'h8, 4'hC, 4'hA, 4'hE, 4'h9, 4'hD, 4'hB, 4'hF
	};

	// Kinds of screen write
	typedef enum logic {
		WR_CELL = 1'b0,
		WR_FILL = 1'b1
	} write_kind_t;

	// Escape parser phase
	typedef enum logic [2:0] {
		PH_TEXT = 3'b001,
		PH_ESC  = 3'b010,
		PH_CSI  = 3'b100
	} phase_t;

	// Decision of the parser on the byte being taken
	typedef struct packed {
		logic print;
		logic line_end;
	} tcw_parse_t;

endpackage

// ----- design/tcw_if.sv -----
interface tcw_char_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

interface tcw_write_if;
	import tcw_pkg::*;

	logic               valid;
	logic               ready;
	logic               write_kind;
	logic [CELL_W-1:0]  cell_index;
	logic [CHAR_W-1:0]  char_code;
	logic [ATTR_W-1:0]  attribute;
	logic [COUNT_W-1:0] fill_count;

	modport source (
		output valid, output write_kind, output cell_index, output char_code,
		output attribute, output fill_count, input ready
	);
	modport sink (
		input valid, input write_kind, input cell_index, input char_code,
		input attribute, input fill_count, output ready
	);
endinterface

// ----- design/tcw_parser.sv -----
module tcw_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic [tcw_pkg::CHAR_W-1:0]        char_byte,
	output tcw_pkg::tcw_parse_t               parse,
	output logic [tcw_pkg::ATTR_W-1:0]        attribute
);
	import tcw_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic [7:0]        acc_q;
	logic [7:0]        acc_d;
	logic [ATTR_W-1:0] attr_q;
	logic [ATTR_W-1:0] attr_d;
	logic              is_digit;
	logic [3:0]        digit;
	logic [11:0]       acc_mac;

	// Apply one SGR code to the attribute; unknown codes leave it alone
	function automatic logic [ATTR_W-1:0] apply_code(
		input logic [7:0]        code,
		input logic [ATTR_W-1:0] attr
	);
		logic [ATTR_W-1:0] res;
		res = attr;
		if (code >= FG_LO && code <= FG_HI) begin
			res = {attr[7:4], ANSI_TO_VGA[{1'b0, 3'(code - FG_LO)}]};
		end else if (code >= BG_LO && code <= BG_HI) begin
			res = {ANSI_TO_VGA[{1'b0, 3'(code - BG_LO)}], attr[3:0]};
		end else if (code >= FG_BRIGHT_LO && code <= FG_BRIGHT_HI) begin
			res = {attr[7:4], ANSI_TO_VGA[{1'b1, 3'(code - FG_BRIGHT_LO)}]};
		end else if (code >= BG_BRIGHT_LO && code <= BG_BRIGHT_HI) begin
			res = {ANSI_TO_VGA[{1'b1, 3'(code - BG_BRIGHT_LO)}], attr[3:0]};
		end
		return res;
	endfunction

	// Accumulate one decimal digit, saturating at the top of the byte
	assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
	assign digit    = 4'(char_byte - CH_ZERO);
	assign acc_mac  = {4'b0, acc_q} * 12'd10 + {8'b0, digit};

	// Step the parser and classify the byte
	always_comb begin
		phase_d        = phase_q;
		acc_d          = acc_q;
		attr_d         = attr_q;
		parse.print    = 1'b0;
		parse.line_end = 1'b0;
		case (phase_q)
			PH_ESC: begin
				if (char_byte == CH_LBRACKET) begin
					phase_d = PH_CSI;
					acc_d   = '0;
				end else begin
					phase_d = PH_TEXT;
				end
			end
			PH_CSI: begin
				if (char_byte == CH_SEMI || char_byte == CH_SGR_END) begin
					attr_d = apply_code(acc_q, attr_q);
					acc_d  = '0;
					if (char_byte == CH_SGR_END) begin
						phase_d = PH_TEXT;
					end
				end else if (is_digit) begin
					acc_d = (acc_mac > 12'd255) ? CODE_SAT : acc_mac[7:0];
				end else begin
					acc_d = CODE_SAT;
				end
			end
			default: begin
				phase_d = PH_TEXT;
				if (char_byte == CH_ESC) begin
					phase_d = PH_ESC;
				end else if (char_byte == CH_LF || char_byte == CH_CR) begin
					parse.line_end = 1'b1;
				end else begin
					parse.print = 1'b1;
				end
			end
		endcase
	end

	// Advance parser state on each taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			acc_q   <= '0;
			attr_q  <= ATTR_RESET;
		end else if (take) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			attr_q  <= attr_d;
		end
	end

	assign attribute = attr_q;

endmodule

// ----- design/text_console_writer_core.sv -----
// A screen write request is registered: it appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle; a byte is taken whenever the output register is
// empty or is being emptied in the same cycle.
// Reset (arst_n low, asynchronous): cursor at row 0 column 0, attribute 0x07,
// parser in normal text, output register empty.
module text_console_writer_core #(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input logic         clk,
	input logic         arst_n,
	tcw_char_if.sink    chars,
	tcw_write_if.source writes
);
	import tcw_pkg::*;

	localparam int COL_W   = $clog2(SCREEN_COLUMNS);
	localparam int ROW_W   = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
	localparam int MUL_W   = ROW_W + COL_W + 1;
	localparam int CELL_XW = (MUL_W > CELL_W) ? MUL_W : CELL_W;
	localparam int CNT_XW  = ((COL_W + 1) > COUNT_W) ? (COL_W + 1) : COUNT_W;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   row_next;
	logic               take;
	logic               emit;
	tcw_parse_t         parse;
	logic [ATTR_W-1:0]  cur_attr;
	logic [CELL_XW-1:0] cell_wide;
	logic [CNT_XW-1:0]  fill_wide;

	logic               out_valid_q;
	logic               kind_q;
	logic [CELL_W-1:0]  cell_q;
	logic [CHAR_W-1:0]  char_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [COUNT_W-1:0] count_q;

	// Take a byte while the output register is free or draining
	assign chars.ready = !out_valid_q || writes.ready;
	assign take        = chars.valid && chars.ready;
	assign emit        = parse.print || parse.line_end;

	tcw_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_byte (chars.char_byte),
		.parse     (parse),
		.attribute (cur_attr)
	);

	// Cell address and run length at the cursor
	assign cell_wide = CELL_XW'(row_q) * CELL_XW'(SCREEN_COLUMNS) + CELL_XW'(col_q);
	assign fill_wide = CNT_XW'(SCREEN_COLUMNS) - CNT_XW'(col_q);
	assign row_next  = (row_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_q + 1'b1;

	// Move the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (parse.line_end) begin
				col_q <= '0;
				row_q <= row_next;
			end else if (parse.print) begin
				if (col_q == COL_W'(SCREEN_COLUMNS - 1)) begin
					col_q <= '0;
					row_q <= row_next;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Hold a request until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (writes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the request payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			cell_q <= cell_wide[CELL_W-1:0];
			if (parse.line_end) begin
				kind_q  <= WR_FILL;
				char_q  <= CH_SPACE;
				attr_q  <= ATTR_NONE;
				count_q <= fill_wide[COUNT_W-1:0];
			end else begin
				kind_q  <= WR_CELL;
				char_q  <= chars.char_byte;
				attr_q  <= cur_attr;
				count_q <= COUNT_W'(1);
			end
		end
	end

	assign writes.valid      = out_valid_q;
	assign writes.write_kind = kind_q;
	assign writes.cell_index = cell_q;
	assign writes.char_code  = char_q;
	assign writes.attribute  = attr_q;
	assign writes.fill_count = count_q;

endmodule
